// File: sv/hps_pkg.sv
package hps_pkg;

    localparam int MAX_NODES = 256;
    localparam int MAX_EDGES = 1024;
    localparam int NODE_W    = $clog2(MAX_NODES);
    localparam int EDGE_AW   = $clog2(MAX_EDGES);
    localparam int LINK_W    = EDGE_AW + 1;
    localparam int NCOUNT_W  = NODE_W + 1;

    localparam logic [LINK_W-1:0]   LINK_END  = LINK_W'(MAX_EDGES);
    localparam logic [NCOUNT_W-1:0] NODES_CAP = NCOUNT_W'(MAX_NODES);
    localparam logic [NODE_W-1:0]   DEPTH_TOP = NODE_W'(MAX_NODES - 1);

    typedef enum logic [1:0] {
        FUNC_CLEAR  = 2'd0,
        FUNC_ADD    = 2'd1,
        FUNC_SEARCH = 2'd2,
        FUNC_READ   = 2'd3
    } func_t;

    localparam logic [2:0] ST_OK        = 3'd0;
    localparam logic [2:0] ST_START_BAD = 3'd1;
    localparam logic [2:0] ST_END_BAD   = 3'd2;
    localparam logic [2:0] ST_NO_PATH   = 3'd3;
    localparam logic [2:0] ST_FULL      = 3'd4;
    localparam logic [2:0] ST_NOT_HELD  = 3'd5;

    typedef struct packed {
        logic              done;
        logic              single;
        logic [NODE_W-1:0] node;
    } scan_res_t;

endpackage

// File: sv/hps_scan.sv
module hps_scan (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                start,
    input  logic [hps_pkg::MAX_NODES-1:0]       flags,
    input  logic [hps_pkg::NCOUNT_W-1:0]        n,
    output hps_pkg::scan_res_t                  res
);

    logic                          run_reg;
    logic                          done_reg;
    logic [hps_pkg::NCOUNT_W-1:0]  i_reg;
    logic [1:0]                    cnt_reg;
    logic [hps_pkg::NODE_W-1:0]    node_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            run_reg  <= 1'b0;
            done_reg <= 1'b0;
            i_reg    <= '0;
            cnt_reg  <= '0;
            node_reg <= '0;
        end
        else
        begin
            done_reg <= 1'b0;
            if (start)
            begin
                run_reg <= 1'b1;
                i_reg   <= '0;
                cnt_reg <= '0;
            end
            else if (run_reg)
            begin
                if (i_reg == n)
                begin
                    run_reg  <= 1'b0;
                    done_reg <= 1'b1;
                end
                else
                begin
                    if (!flags[i_reg[hps_pkg::NODE_W-1:0]])
                    begin
                        if (cnt_reg != 2'd2)
                            cnt_reg <= cnt_reg + 2'd1;
                        node_reg <= i_reg[hps_pkg::NODE_W-1:0];
                    end
                    i_reg <= i_reg + 1'b1;
                end
            end
        end
    end

    assign res.done   = done_reg;
    assign res.single = (cnt_reg == 2'd1);
    assign res.node   = node_reg;

endmodule

// File: sv/hamiltonian_path_search_top.sv
// channel | direction | handshake               | beat
// cfg     | in        | cfg_valid / cfg_ready   | cfg_data (node_count)
// in      | in        | in_valid / in_stall     | func, edge_from, edge_to, slot
// out     | out       | out_valid / out_stall   | status, node
// Clear and rejected edge adds answer from idle; a stored edge add goes through S_ADD
// and a path read through S_READ. Search: two node scans (n = node_count capped at 256),
// then a walk that enters nodes, tries edges and backtracks.
// Reset clears flags, counters and held path; edge and stack memories need none.
// in_stall is high while an item is at work or a result beat waits on out_stall.
module hamiltonian_path_search_top (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic [8:0]  cfg_data,
    input  logic        in_valid,
    output logic        in_stall,
    input  logic [1:0]  func,
    input  logic [7:0]  edge_from,
    input  logic [7:0]  edge_to,
    input  logic [7:0]  slot,
    output logic        out_valid,
    input  logic        out_stall,
    output logic [2:0]  status,
    output logic [7:0]  node
);

    localparam int NW = hps_pkg::NODE_W;
    localparam int EW = hps_pkg::EDGE_AW;
    localparam int LW = hps_pkg::LINK_W;
    localparam int CW = hps_pkg::NCOUNT_W;
    localparam int NN = hps_pkg::MAX_NODES;
    localparam int NE = hps_pkg::MAX_EDGES;

    typedef enum logic [3:0] {
        S_IDLE, S_ADD, S_READ, S_SCAN_IN, S_SCAN_OUT,
        S_ENTER0, S_ENTER1, S_LOOP0, S_LOOP1, S_LOOP2
    } state_t;

    state_t          state_reg;
    logic            out_valid_reg;
    logic [2:0]      status_reg;
    logic [NW-1:0]   node_reg;
    logic [CW-1:0]   node_count_reg;
    logic [EW:0]     edges_stored_reg;
    logic [NN-1:0]   has_in_reg;
    logic [NN-1:0]   has_out_reg;
    logic [NN-1:0]   on_path_reg;
    logic [NN-1:0]   reached_reg;
    logic            path_valid_reg;
    logic [CW-1:0]   path_len_reg;
    logic [NW-1:0]   from_reg;
    logic [NW-1:0]   to_reg;
    logic            had_out_reg;
    logic [NW-1:0]   slot_reg;
    logic [NW-1:0]   v_reg;
    logic [NW-1:0]   d_reg;
    logic [NW-1:0]   end_reg;
    logic            is_start_reg;

    logic [NW-1:0]   et_mem [NE];
    logic [LW-1:0]   el_mem [NE];
    logic [EW-1:0]   lh_mem [NN];
    logic [EW-1:0]   lt_mem [NN];
    logic [NW-1:0]   dr_mem [NN];
    logic [NW-1:0]   sn_mem [NN];
    logic [LW-1:0]   sc_mem [NN];

    logic [NW-1:0]   et_rd;
    logic [LW-1:0]   el_rd;
    logic [EW-1:0]   lh_rd;
    logic [EW-1:0]   lt_rd;
    logic [NW-1:0]   dr_rd;
    logic [NW-1:0]   sn_rd;
    logic [LW-1:0]   sc_rd;

    logic            et_we, el_we, lh_we, lt_we, dr_we, sn_we, sc_we;
    logic [EW-1:0]   et_waddr, el_waddr, lh_waddr, lt_waddr;
    logic [NW-1:0]   dr_waddr, sn_waddr, sc_waddr;
    logic [LW-1:0]   el_wdata, sc_wdata;
    logic [NW-1:0]   sn_raddr;
    logic [EW-1:0]   edge_raddr;

    logic            in_acc;
    logic            out_free;
    logic [CW-1:0]   n_eff;
    logic [EW-1:0]   e_idx;
    logic            full;
    logic            reach_hit;
    logic            pruned;
    logic            scan_start;
    logic [NN-1:0]   scan_flags;
    hps_pkg::scan_res_t scan_res;

    assign cfg_ready = 1'b1;
    assign out_free  = !out_valid_reg || !out_stall;
    assign in_stall  = (state_reg != S_IDLE) || !out_free;
    assign in_acc    = in_valid && !in_stall;
    assign out_valid = out_valid_reg;
    assign status    = status_reg;
    assign node      = node_reg;

    assign n_eff  = (node_count_reg > hps_pkg::NODES_CAP) ? hps_pkg::NODES_CAP
                                                         : node_count_reg;
    assign e_idx  = edges_stored_reg[EW-1:0];
    assign full   = (edges_stored_reg == (EW+1)'(NE));
    // end node at the wrong depth is still marked reached
    assign reach_hit = reached_reg[v_reg] && (dr_rd >= d_reg);
    assign pruned    = reach_hit
                    || ((v_reg == end_reg) && (({1'b0, d_reg} + 1'b1) != n_eff));

    assign scan_start = (in_acc && (func == hps_pkg::FUNC_SEARCH))
                     || ((state_reg == S_SCAN_IN) && scan_res.done && scan_res.single);
    assign scan_flags = (state_reg == S_SCAN_OUT) ? has_out_reg : has_in_reg;

    hps_scan u_scan (
        .clk   (clk),
        .rst_n (rst_n),
        .start (scan_start),
        .flags (scan_flags),
        .n     (n_eff),
        .res   (scan_res)
    );

    always_comb
    begin
        et_we    = 1'b0;
        et_waddr = e_idx;
        el_we    = 1'b0;
        el_waddr = e_idx;
        el_wdata = hps_pkg::LINK_END;
        lh_we    = 1'b0;
        lh_waddr = e_idx;
        lt_we    = 1'b0;
        lt_waddr = e_idx;
        dr_we    = 1'b0;
        dr_waddr = v_reg;
        sn_we    = 1'b0;
        sn_waddr = d_reg;
        sc_we    = 1'b0;
        sc_waddr = d_reg;
        sc_wdata = el_rd;
        sn_raddr = d_reg;
        edge_raddr = sc_rd[EW-1:0];
        unique case (state_reg)
            S_IDLE:
            begin
                sn_raddr = slot;
                if (in_acc && (func == hps_pkg::FUNC_ADD) && !full)
                begin
                    et_we = 1'b1;
                    el_we = 1'b1;
                end
            end
            S_ADD:
            begin
                el_we    = had_out_reg;
                el_waddr = lt_rd;
                el_wdata = {1'b0, e_idx};
                lh_we    = !had_out_reg;
                lh_waddr = e_idx;
                lt_we    = 1'b1;
            end
            S_ENTER0:
            begin
                sn_we = 1'b1;
            end
            S_ENTER1:
            begin
                if (!reach_hit)
                    dr_we = 1'b1;
                if (!pruned && (v_reg != end_reg))
                begin
                    sc_we    = 1'b1;
                    sc_wdata = has_out_reg[v_reg] ? {1'b0, lh_rd} : hps_pkg::LINK_END;
                end
            end
            S_LOOP2:
            begin
                sc_we = 1'b1;
            end
            default:
            begin
            end
        endcase
    end

    always_ff @(posedge clk)
    begin
        if (et_we)
            et_mem[et_waddr] <= edge_to;
        et_rd <= et_mem[edge_raddr];
    end

    always_ff @(posedge clk)
    begin
        if (el_we)
            el_mem[el_waddr] <= el_wdata;
        el_rd <= el_mem[edge_raddr];
    end

    always_ff @(posedge clk)
    begin
        if (lh_we)
            lh_mem[from_reg] <= lh_waddr;
        lh_rd <= lh_mem[v_reg];
    end

    always_ff @(posedge clk)
    begin
        if (lt_we)
            lt_mem[from_reg] <= lt_waddr;
        lt_rd <= lt_mem[edge_from];
    end

    always_ff @(posedge clk)
    begin
        if (dr_we)
            dr_mem[dr_waddr] <= d_reg;
        dr_rd <= dr_mem[v_reg];
    end

    always_ff @(posedge clk)
    begin
        if (sn_we)
            sn_mem[sn_waddr] <= v_reg;
        sn_rd <= sn_mem[sn_raddr];
    end

    always_ff @(posedge clk)
    begin
        if (sc_we)
            sc_mem[sc_waddr] <= sc_wdata;
        sc_rd <= sc_mem[d_reg];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg        <= S_IDLE;
            out_valid_reg    <= 1'b0;
            status_reg       <= '0;
            node_reg         <= '0;
            node_count_reg   <= CW'(1);
            edges_stored_reg <= '0;
            has_in_reg       <= '0;
            has_out_reg      <= '0;
            on_path_reg      <= '0;
            reached_reg      <= '0;
            path_valid_reg   <= 1'b0;
            path_len_reg     <= '0;
            from_reg         <= '0;
            to_reg           <= '0;
            had_out_reg      <= 1'b0;
            slot_reg         <= '0;
            v_reg            <= '0;
            d_reg            <= '0;
            end_reg          <= '0;
            is_start_reg     <= 1'b0;
        end
        else
        begin
            if (cfg_valid && cfg_ready)
                node_count_reg <= cfg_data;

            unique case (state_reg)
                S_IDLE:
                begin
                    if (in_acc)
                    begin
                        from_reg      <= edge_from;
                        to_reg        <= edge_to;
                        slot_reg      <= slot;
                        had_out_reg   <= has_out_reg[edge_from];
                        node_reg      <= '0;
                        status_reg    <= hps_pkg::ST_OK;
                        out_valid_reg <= (func == hps_pkg::FUNC_CLEAR)
                                      || ((func == hps_pkg::FUNC_ADD) && full);
                        unique case (hps_pkg::func_t'(func))
                            hps_pkg::FUNC_CLEAR:
                            begin
                                has_in_reg       <= '0;
                                has_out_reg      <= '0;
                                edges_stored_reg <= '0;
                                path_valid_reg   <= 1'b0;
                                path_len_reg     <= '0;
                            end
                            hps_pkg::FUNC_ADD:
                            begin
                                if (full)
                                    status_reg <= hps_pkg::ST_FULL;
                                else
                                    state_reg <= S_ADD;
                            end
                            hps_pkg::FUNC_SEARCH:
                            begin
                                path_valid_reg <= 1'b0;
                                path_len_reg   <= '0;
                                state_reg      <= S_SCAN_IN;
                            end
                            hps_pkg::FUNC_READ:
                                state_reg <= S_READ;
                        endcase
                    end
                    else if (out_valid_reg && !out_stall)
                        out_valid_reg <= 1'b0;
                end
                S_ADD:
                begin
                    has_out_reg[from_reg] <= 1'b1;
                    has_in_reg[to_reg]    <= 1'b1;
                    edges_stored_reg      <= edges_stored_reg + 1'b1;
                    out_valid_reg         <= 1'b1;
                    state_reg             <= S_IDLE;
                end
                S_READ:
                begin
                    if (path_valid_reg && ({1'b0, slot_reg} < path_len_reg))
                        node_reg <= sn_rd;
                    else
                        status_reg <= hps_pkg::ST_NOT_HELD;
                    out_valid_reg <= 1'b1;
                    state_reg     <= S_IDLE;
                end
                S_SCAN_IN:
                begin
                    if (scan_res.done)
                    begin
                        if (scan_res.single)
                        begin
                            v_reg     <= scan_res.node;
                            state_reg <= S_SCAN_OUT;
                        end
                        else
                        begin
                            status_reg    <= hps_pkg::ST_START_BAD;
                            out_valid_reg <= 1'b1;
                            state_reg     <= S_IDLE;
                        end
                    end
                end
                S_SCAN_OUT:
                begin
                    if (scan_res.done)
                    begin
                        if (scan_res.single)
                        begin
                            end_reg      <= scan_res.node;
                            on_path_reg  <= NN'(1) << v_reg;
                            reached_reg  <= '0;
                            d_reg        <= '0;
                            is_start_reg <= 1'b1;
                            state_reg    <= S_ENTER0;
                        end
                        else
                        begin
                            status_reg    <= hps_pkg::ST_END_BAD;
                            out_valid_reg <= 1'b1;
                            state_reg     <= S_IDLE;
                        end
                    end
                end
                S_ENTER0:
                    state_reg <= S_ENTER1;
                S_ENTER1:
                begin
                    if (!reach_hit)
                        reached_reg[v_reg] <= 1'b1;
                    if (pruned)
                    begin
                        if (is_start_reg)
                        begin
                            status_reg    <= hps_pkg::ST_NO_PATH;
                            out_valid_reg <= 1'b1;
                            state_reg     <= S_IDLE;
                        end
                        else
                        begin
                            on_path_reg[v_reg] <= 1'b0;
                            d_reg              <= d_reg - 1'b1;
                            state_reg          <= S_LOOP0;
                        end
                    end
                    else if (v_reg == end_reg)
                    begin
                        path_valid_reg <= 1'b1;
                        path_len_reg   <= n_eff;
                        out_valid_reg  <= 1'b1;
                        state_reg      <= S_IDLE;
                    end
                    else
                        state_reg <= S_LOOP0;
                end
                S_LOOP0:
                    state_reg <= S_LOOP1;
                S_LOOP1:
                begin
                    if (sc_rd[EW])
                    begin
                        if (d_reg == '0)
                        begin
                            status_reg    <= hps_pkg::ST_NO_PATH;
                            out_valid_reg <= 1'b1;
                            state_reg     <= S_IDLE;
                        end
                        else
                        begin
                            on_path_reg[sn_rd] <= 1'b0;
                            d_reg              <= d_reg - 1'b1;
                            state_reg          <= S_LOOP0;
                        end
                    end
                    else
                        state_reg <= S_LOOP2;
                end
                S_LOOP2:
                begin
                    if (on_path_reg[et_rd] || (d_reg == hps_pkg::DEPTH_TOP))
                        state_reg <= S_LOOP0;
                    else
                    begin
                        on_path_reg[et_rd] <= 1'b1;
                        v_reg              <= et_rd;
                        d_reg              <= d_reg + 1'b1;
                        is_start_reg       <= 1'b0;
                        state_reg          <= S_ENTER0;
                    end
                end
                default:
                    state_reg <= S_IDLE;
            endcase
        end
    end

    a_busy_stalls: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg != S_IDLE) |-> in_stall)
        else $error("input taken while an item is at work");

    a_single_result: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg != S_IDLE) |-> !out_valid_reg)
        else $error("result beat pending during item work");

    a_edges_bound: assert property (@(posedge clk) disable iff (!rst_n)
        edges_stored_reg <= (EW+1)'(NE))
        else $error("edge count past store depth");

    a_path_len: assert property (@(posedge clk) disable iff (!rst_n)
        path_valid_reg |-> (path_len_reg != '0))
        else $error("held path with zero length");

    a_search_start: assert property (@(posedge clk) disable iff (!rst_n)
        (in_acc && (func == hps_pkg::FUNC_SEARCH)) |=> !path_valid_reg)
        else $error("held path survived a search start");

endmodule

// File: dv/testbench.sv
module testbench;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int STALL_LIMIT = 200000;

    class path_scoreboard;
        bit [7:0]  edge_dst [hps_pkg::MAX_EDGES];
        bit [10:0] edge_next [hps_pkg::MAX_EDGES];
        bit [9:0]  head [hps_pkg::MAX_NODES];
        bit [9:0]  tail [hps_pkg::MAX_NODES];
        bit        incoming [hps_pkg::MAX_NODES];
        bit        outgoing [hps_pkg::MAX_NODES];
        int        stored;
        bit        on_route [hps_pkg::MAX_NODES];
        bit        seen [hps_pkg::MAX_NODES];
        int        seen_depth [hps_pkg::MAX_NODES];
        bit [7:0]  route [hps_pkg::MAX_NODES];
        int        cursor [hps_pkg::MAX_NODES];
        bit        held;
        int        route_len;
        bit [8:0]  node_total;
        bit [10:0] pending_q [$];
        int        mismatches;

        function new();
            node_total = 1;
            mismatches = 0;
            wipe();
        endfunction

        function void wipe();
            for (int i = 0; i < hps_pkg::MAX_NODES; i++)
            begin
                incoming[i] = 0;
                outgoing[i] = 0;
            end
            stored = 0;
            held = 0;
            route_len = 0;
        endfunction

        function bit [2:0] add(int from, int to);
            if (stored >= hps_pkg::MAX_EDGES)
                return hps_pkg::ST_FULL;
            edge_dst[stored] = 8'(to);
            edge_next[stored] = 11'(hps_pkg::MAX_EDGES);
            if (outgoing[from])
                edge_next[tail[from]] = 11'(stored);
            else
                head[from] = 10'(stored);
            tail[from] = 10'(stored);
            outgoing[from] = 1;
            incoming[to] = 1;
            stored++;
            return hps_pkg::ST_OK;
        endfunction

        function int enter(int v, int d, int fin, int n);
            route[d] = 8'(v);
            if (seen[v] && seen_depth[v] >= d)
                return 1;
            seen[v] = 1;
            seen_depth[v] = d;
            if (v == fin)
                return (d + 1 == n) ? 2 : 1;
            cursor[d] = outgoing[v] ? int'(head[v]) : hps_pkg::MAX_EDGES;
            return 0;
        endfunction

        function bit [2:0] search();
            int n, cnt, st, fin, d, c, t, r;
            held = 0;
            route_len = 0;
            n = (int'(node_total) > hps_pkg::MAX_NODES) ? hps_pkg::MAX_NODES
                                                       : int'(node_total);
            cnt = 0;
            st = 0;
            fin = 0;
            d = 0;
            for (int i = 0; i < n; i++)
                if (!incoming[i])
                begin
                    st = i;
                    cnt++;
                end
            if (cnt != 1)
                return hps_pkg::ST_START_BAD;
            cnt = 0;
            for (int i = 0; i < n; i++)
                if (!outgoing[i])
                begin
                    fin = i;
                    cnt++;
                end
            if (cnt != 1)
                return hps_pkg::ST_END_BAD;
            for (int i = 0; i < hps_pkg::MAX_NODES; i++)
            begin
                on_route[i] = 0;
                seen[i] = 0;
                seen_depth[i] = 0;
            end
            on_route[st] = 1;
            r = enter(st, 0, fin, n);
            if (r == 2)
            begin
                held = 1;
                route_len = n;
                return hps_pkg::ST_OK;
            end
            if (r == 1)
                return hps_pkg::ST_NO_PATH;
            while (1)
            begin
                c = cursor[d];
                if (c >= hps_pkg::MAX_EDGES)
                begin
                    if (d == 0)
                        return hps_pkg::ST_NO_PATH;
                    on_route[route[d]] = 0;
                    d--;
                end
                else
                begin
                    cursor[d] = int'(edge_next[c]);
                    t = int'(edge_dst[c]);
                    if (!on_route[t] && d + 1 < hps_pkg::MAX_NODES)
                    begin
                        on_route[t] = 1;
                        r = enter(t, d + 1, fin, n);
                        if (r == 2)
                        begin
                            held = 1;
                            route_len = n;
                            return hps_pkg::ST_OK;
                        end
                        if (r == 1)
                            on_route[t] = 0;
                        else
                            d++;
                    end
                end
            end
        endfunction

        function void note_input(bit [1:0] f, bit [7:0] from, bit [7:0] to, bit [7:0] s);
            bit [2:0] st;
            bit [7:0] nd;
            st = hps_pkg::ST_OK;
            nd = 0;
            case (hps_pkg::func_t'(f))
                hps_pkg::FUNC_CLEAR:  wipe();
                hps_pkg::FUNC_ADD:    st = add(int'(from), int'(to));
                hps_pkg::FUNC_SEARCH: st = search();
                default:
                    if (held && s < route_len)
                        nd = route[s];
                    else
                        st = hps_pkg::ST_NOT_HELD;
            endcase
            pending_q.insert(pending_q.size(), {st, nd});
        endfunction

        function void check(bit [2:0] st, bit [7:0] nd);
            bit [10:0] want;
            if (pending_q.size() == 0)
            begin
                mismatches++;
                if (mismatches <= 10)
                    $display("unexpected result beat status=%0d node=%0d", st, nd);
                return;
            end
            want = pending_q.pop_front();
            if (want != {st, nd})
            begin
                mismatches++;
                if (mismatches <= 10)
                    $display("mismatch: expected status=%0d node=%0d, got status=%0d node=%0d",
                             want[10:8], want[7:0], st, nd);
            end
        endfunction
    endclass

    logic       clk;
    logic       rst_n;
    logic       cfg_valid;
    logic       cfg_ready;
    logic [8:0] cfg_data;
    logic       in_valid;
    logic       in_stall;
    logic [1:0] func;
    logic [7:0] edge_from;
    logic [7:0] edge_to;
    logic [7:0] slot;
    logic       out_valid;
    logic       out_stall = 1'b0;
    logic [2:0] status;
    logic [7:0] node;

    path_scoreboard sb;
    int idle_cycles = 0;
    int burst_left;
    int items_sent;
    int stall_mode = 0;
    int mode_timer = 0;

    hamiltonian_path_search_top dut (
        .clk(clk), .rst_n(rst_n),
        .cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_data(cfg_data),
        .in_valid(in_valid), .in_stall(in_stall),
        .func(func), .edge_from(edge_from), .edge_to(edge_to), .slot(slot),
        .out_valid(out_valid), .out_stall(out_stall),
        .status(status), .node(node)
    );

    initial
    begin
        clk = 0;
        forever #2 clk = ~clk;
    end

    // receiver: stall density is re-drawn each time mode_timer runs down to zero
    always @(posedge clk)
    begin
        if (rst_n && out_valid && !out_stall)
            sb.check(status, node);
        if (mode_timer == 0)
        begin
            stall_mode <= $urandom_range(0, 3);
            mode_timer <= 32;
        end
        else
            mode_timer <= mode_timer - 1;
        case (stall_mode)
            0: out_stall <= 0;
            1: out_stall <= ($urandom_range(0, 3) == 0);
            2: out_stall <= $urandom_range(0, 1);
            default: out_stall <= ($urandom_range(0, 9) != 0);
        endcase
    end

    always @(posedge clk)
    begin
        if ((in_valid && !in_stall) || (out_valid && !out_stall) || (cfg_valid && cfg_ready))
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles >= STALL_LIMIT)
        begin
            $display("FAILURE");
            $finish;
        end
    end

    task automatic send(int f, int a, int b, int s);
        int gap;
        if (burst_left == 0)
        begin
            burst_left = $urandom_range(1, 20);
            gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
            if (gap > 0 && in_valid)
            begin
                in_valid <= 0;
                repeat (gap) @(posedge clk);
            end
        end
        burst_left--;
        in_valid <= 1;
        func <= 2'(f);
        edge_from <= 8'(a);
        edge_to <= 8'(b);
        slot <= 8'(s);
        do
            @(posedge clk);
        while (in_stall);
        sb.note_input(2'(f), 8'(a), 8'(b), 8'(s));
        items_sent++;
    endtask

    task automatic drain();
        if (in_valid)
        begin
            in_valid <= 0;
            @(posedge clk);
        end
        while (sb.pending_q.size() != 0)
            @(posedge clk);
        repeat (8) @(posedge clk);
    endtask

    task automatic write_count(int v);
        drain();
        cfg_valid <= 1;
        cfg_data <= 9'(v);
        do
            @(posedge clk);
        while (!cfg_ready);
        cfg_valid <= 0;
        sb.node_total = 9'(v);
        burst_left = 0;
    endtask

    // graph phase: shuffled chain plus extra edges that keep start and end unique; noisy mode mixes in random items
    task automatic graph_phase(int n, int extra, bit noisy);
        int order [hps_pkg::MAX_NODES];
        int j, tmp, k, a, b;
        write_count(n);
        send(hps_pkg::FUNC_CLEAR, $urandom, $urandom, $urandom);
        for (int i = 0; i < n; i++)
            order[i] = i;
        for (int i = n - 1; i > 0; i--)
        begin
            j = $urandom_range(0, i);
            tmp = order[i];
            order[i] = order[j];
            order[j] = tmp;
        end
        k = 0;
        for (int i = 0; i + 1 < n || extra > 0; )
        begin
            if (extra > 0 && (i + 1 >= n || $urandom_range(0, 2) == 0))
            begin
                a = order[$urandom_range(0, n - 2 < 0 ? 0 : n - 2)];
                b = order[$urandom_range(n > 1 ? 1 : 0, n - 1)];
                if (n > 1)
                    send(hps_pkg::FUNC_ADD, a, b, $urandom);
                extra--;
            end
            else
            begin
                send(hps_pkg::FUNC_ADD, order[i], order[i + 1], $urandom);
                i++;
            end
            if (noisy && $urandom_range(0, 9) == 0)
                send($urandom, $urandom, $urandom, $urandom);
        end
        if (noisy && $urandom_range(0, 3) == 0)
            send(hps_pkg::FUNC_READ, $urandom, $urandom, $urandom);
        send(hps_pkg::FUNC_SEARCH, $urandom, $urandom, $urandom);
        for (int i = 0; i < n && i < 16; i++)
            send(hps_pkg::FUNC_READ, $urandom, $urandom, i);
        send(hps_pkg::FUNC_READ, $urandom, $urandom, $urandom);
        send(hps_pkg::FUNC_READ, $urandom, $urandom, n < 256 ? n : 255);
        if ($urandom_range(0, 1))
        begin
            send(hps_pkg::FUNC_ADD, order[0], order[n - 1], $urandom);
            send(hps_pkg::FUNC_READ, $urandom, $urandom, 0);
        end
    endtask

    initial
    begin
        sb = new();
        rst_n = 0;
        cfg_valid <= 0;
        cfg_data <= 0;
        in_valid <= 0;
        func <= 0;
        edge_from <= 0;
        edge_to <= 0;
        slot <= 0;
        burst_left = 0;
        items_sent = 0;
        repeat (11) @(posedge clk);
        rst_n <= 1;
        @(posedge clk);

        // directed: reset count of one, read before any path, edges at the extremes
        send(hps_pkg::FUNC_READ, 0, 0, 0);
        send(hps_pkg::FUNC_SEARCH, 0, 0, 0);
        send(hps_pkg::FUNC_READ, 0, 0, 0);
        send(hps_pkg::FUNC_READ, 0, 0, 1);
        send(hps_pkg::FUNC_ADD, 255, 0, 0);
        send(hps_pkg::FUNC_READ, 0, 0, 0);
        send(hps_pkg::FUNC_ADD, 0, 255, 255);
        send(hps_pkg::FUNC_SEARCH, 0, 0, 0);
        send(hps_pkg::FUNC_CLEAR, 255, 255, 255);
        send(hps_pkg::FUNC_READ, 0, 0, 0);
        write_count(0);
        send(hps_pkg::FUNC_SEARCH, 0, 0, 0);
        write_count(2);
        send(hps_pkg::FUNC_ADD, 0, 1, 0);
        send(hps_pkg::FUNC_ADD, 1, 0, 0);
        send(hps_pkg::FUNC_SEARCH, 0, 0, 0);
        send(hps_pkg::FUNC_CLEAR, 0, 0, 0);
        send(hps_pkg::FUNC_ADD, 1, 0, 0);
        send(hps_pkg::FUNC_ADD, 1, 200, 0);
        send(hps_pkg::FUNC_SEARCH, 0, 0, 0);
        send(hps_pkg::FUNC_READ, 0, 0, 1);
        write_count(3);
        send(hps_pkg::FUNC_ADD, 0, 2, 0);
        send(hps_pkg::FUNC_SEARCH, 0, 0, 0);
        write_count(256);
        send(hps_pkg::FUNC_SEARCH, 0, 0, 0);
        write_count(300);
        send(hps_pkg::FUNC_SEARCH, 0, 0, 0);

        // longest chain
        graph_phase(256, 0, 0);
        graph_phase(1, 0, 0);

        while (items_sent < 550)
            graph_phase($urandom_range(2, 12), $urandom_range(0, 10), 1);

        drain();
        repeat (20) @(posedge clk);
        if (sb.mismatches == 0 && sb.pending_q.size() == 0)
            $display("SUCCESS");
        else
            $display("FAILURE");
        $finish;
    end
endmodule

// File: files.f
sv/hps_pkg.sv
sv/hps_scan.sv
sv/hamiltonian_path_search_top.sv
dv/testbench.sv
